/* rtl/software_timer_pool_defines.svh */
// Assertion macros shared by the timer pool RTL.
`ifndef SOFTWARE_TIMER_POOL_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define STP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer pool: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define STP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer pool: next-cycle check failed");

`endif

/* rtl/stp_pkg.sv */
// Shared types and codes for the timer pool.
`default_nettype none

package stp_pkg;

	localparam int CMD_W  = 2;
	localparam int TIME_W = 16;
	localparam int ID_W   = 5;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KILL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

	localparam logic [CMD_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] KIND_KILL   = 2'd1;
	localparam logic [CMD_W-1:0] KIND_QUERY  = 2'd2;
	localparam logic [CMD_W-1:0] KIND_EXPIRE = 2'd3;

	// Controller to datapath strobes.
	typedef struct packed {
		logic accept;
		logic scan_inc;
		logic mem_rd;
		logic add_take;
		logic kill_chk;
		logic tick_upd;
		logic emit_fire;
		logic emit_reply;
		logic emit_pend_last;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [CMD_W-1:0] req_cmd;
		logic             slot_free;
		logic             scan_last;
		logic             kill_ok;
		logic             fire;
		logic             need_emit;
		logic             pend;
		logic             out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/stp_cmd_if.sv */
// Command channel interface.
`default_nettype none

interface stp_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [stp_pkg::CMD_W-1:0]   command;
	logic [stp_pkg::TIME_W-1:0]  timeout_ms;
	logic [stp_pkg::ID_W-1:0]    timer_id;
	logic                        fire_now;

	modport source (output valid, output command, output timeout_ms, output timer_id,
		output fire_now, input ready);
	modport sink (input valid, input command, input timeout_ms, input timer_id,
		input fire_now, output ready);
endinterface

`default_nettype wire

/* rtl/stp_res_if.sv */
// Result channel interface.
`default_nettype none

interface stp_res_if;
	logic                       valid;
	logic                       ready;
	logic [stp_pkg::CMD_W-1:0]  kind;
	logic [stp_pkg::ID_W-1:0]   slot_id;
	logic                       success;
	logic                       running;
	logic                       last;

	modport source (output valid, output kind, output slot_id, output success,
		output running, output last, input ready);
	modport sink (input valid, input kind, input slot_id, input success,
		input running, input last, output ready);
endinterface

`default_nettype wire

/* rtl/stp_datapath.sv */
// Timer pool datapath: count memory, running flags, scan index, result register.
`default_nettype none
`include "software_timer_pool_defines.svh"

module stp_datapath #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire stp_pkg::ctl_cmd_t          ctl,
	output stp_pkg::dp_stat_t               stat,
	input  wire logic [stp_pkg::CMD_W-1:0]  req_command,
	input  wire logic [stp_pkg::TIME_W-1:0] req_timeout_ms,
	input  wire logic [stp_pkg::ID_W-1:0]   req_timer_id,
	input  wire logic                       req_fire_now,
	input  wire logic                       rsp_ready,
	output logic                            rsp_valid,
	output logic [stp_pkg::CMD_W-1:0]       rsp_kind,
	output logic [stp_pkg::ID_W-1:0]        rsp_slot_id,
	output logic                            rsp_success,
	output logic                            rsp_running,
	output logic                            rsp_last
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int SUM_W = IDX_W + stp_pkg::ID_W;

	// latched item
	logic [stp_pkg::CMD_W-1:0]  cmd_q;
	logic [stp_pkg::TIME_W-1:0] timeout_q;
	logic [stp_pkg::ID_W-1:0]   id_q;
	logic                       fire_q;

	logic [IDX_W-1:0]           scan_q;
	logic [stp_pkg::ID_W-1:0]   got_q;
	logic                       ok_q;
	logic                       pend_q;
	logic [stp_pkg::ID_W-1:0]   pend_id_q;
	logic [NUM_TIMERS-1:0]      run_q;
	logic [stp_pkg::TIME_W-1:0] rd_q;
	logic [stp_pkg::TIME_W-1:0] mem [NUM_TIMERS];

	logic                       out_valid_q;
	logic [stp_pkg::CMD_W-1:0]  out_kind_q;
	logic [stp_pkg::ID_W-1:0]   out_id_q;
	logic                       out_ok_q;
	logic                       out_run_q;
	logic                       out_last_q;

	logic [stp_pkg::ID_W-1:0]   id_m1;
	logic [SUM_W-1:0]           id_ext;
	logic [IDX_W-1:0]           kidx;
	logic                       id_ok;
	logic [SUM_W-1:0]           scan_num;
	logic [stp_pkg::ID_W-1:0]   scan_id;
	logic                       live;
	logic                       expire;
	logic                       kill_ok;
	logic                       qry_run;
	logic [IDX_W-1:0]           rd_addr;
	logic                       out_free;
	logic                       tick_emit;
	logic                       load;
	logic [stp_pkg::CMD_W-1:0]  nxt_kind;
	logic [stp_pkg::ID_W-1:0]   nxt_id;
	logic                       nxt_ok;
	logic                       nxt_run;
	logic                       nxt_last;

	// id counted from 1 -> slot index
	assign id_m1   = id_q - stp_pkg::ID_W'(1);
	assign id_ext  = SUM_W'(id_m1);
	assign kidx    = id_ext[IDX_W-1:0];
	assign id_ok   = (id_q != '0) && (7'(id_q) <= 7'(NUM_TIMERS));

	assign scan_num = SUM_W'(scan_q) + SUM_W'(1);
	assign scan_id  = scan_num[stp_pkg::ID_W-1:0];

	assign live    = run_q[scan_q] && (rd_q != '0);
	assign expire  = live && (rd_q == stp_pkg::TIME_W'(1));
	assign kill_ok = id_ok && run_q[kidx] && (rd_q != '0);
	assign qry_run = id_ok && run_q[kidx];
	assign rd_addr = (cmd_q == stp_pkg::CMD_TICK) ? scan_q : kidx;

	assign out_free  = !out_valid_q || rsp_ready;
	assign tick_emit = ctl.tick_upd && expire && pend_q;
	assign load      = ctl.emit_fire || ctl.emit_reply || ctl.emit_pend_last || tick_emit;

	always_comb begin
		stat.req_cmd   = req_command;
		stat.slot_free = !run_q[scan_q];
		stat.scan_last = (scan_q == IDX_W'(NUM_TIMERS - 1));
		stat.kill_ok   = kill_ok;
		stat.fire      = fire_q;
		stat.need_emit = expire && pend_q;
		stat.pend      = pend_q;
		stat.out_free  = out_free;
	end

	// next result item
	always_comb begin
		nxt_kind = stp_pkg::KIND_EXPIRE;
		nxt_id   = pend_id_q;
		nxt_ok   = 1'b0;
		nxt_run  = 1'b0;
		nxt_last = ctl.emit_pend_last;
		if (ctl.emit_fire) begin
			nxt_id = id_q;
		end else if (ctl.emit_reply) begin
			nxt_last = 1'b1;
			nxt_ok   = ok_q;
			nxt_id   = id_q;
			case (cmd_q)
				stp_pkg::CMD_ADD: begin
					nxt_kind = stp_pkg::KIND_ADD;
					nxt_id   = got_q;
				end
				stp_pkg::CMD_KILL: begin
					nxt_kind = stp_pkg::KIND_KILL;
				end
				stp_pkg::CMD_QUERY: begin
					nxt_kind = stp_pkg::KIND_QUERY;
					nxt_run  = qry_run;
				end
				default: begin
					nxt_kind = stp_pkg::KIND_EXPIRE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			pend_q      <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				scan_q <= '0;
				pend_q <= 1'b0;
			end else if (ctl.scan_inc) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (ctl.add_take) begin
				run_q[scan_q] <= 1'b1;
			end
			if (ctl.kill_chk && kill_ok) begin
				run_q[kidx] <= 1'b0;
			end
			if (ctl.tick_upd && expire) begin
				run_q[scan_q] <= 1'b0;
				pend_q        <= 1'b1;
			end
			if (ctl.emit_pend_last) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q     <= req_command;
			timeout_q <= req_timeout_ms;
			id_q      <= req_timer_id;
			fire_q    <= req_fire_now;
			got_q     <= '0;
			ok_q      <= 1'b0;
		end
		if (ctl.add_take) begin
			got_q <= scan_id;
			ok_q  <= 1'b1;
		end
		if (ctl.kill_chk) begin
			ok_q <= kill_ok;
		end
		if (ctl.tick_upd && expire) begin
			pend_id_q <= scan_id;
		end
		if (load) begin
			out_kind_q <= nxt_kind;
			out_id_q   <= nxt_id;
			out_ok_q   <= nxt_ok;
			out_run_q  <= nxt_run;
			out_last_q <= nxt_last;
		end
	end

	// count memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.add_take) begin
			mem[scan_q] <= timeout_q;
		end else if (ctl.tick_upd && live) begin
			mem[scan_q] <= rd_q - stp_pkg::TIME_W'(1);
		end
		if (ctl.mem_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_kind    = out_kind_q;
	assign rsp_slot_id = out_id_q;
	assign rsp_success = out_ok_q;
	assign rsp_running = out_run_q;
	assign rsp_last    = out_last_q;

	`STP_ASSERT_IMPL(a_take_free, ctl.add_take, !run_q[scan_q])
	`STP_ASSERT_NEXT(a_kill_frees, ctl.kill_chk && kill_ok, !run_q[$past(kidx)])
	`STP_ASSERT_NEXT(a_pend_done, ctl.emit_pend_last, !pend_q)

endmodule

`default_nettype wire

/* rtl/stp_ctrl.sv */
// Timer pool controller: sequences add scan, kill check, query and tick sweep.
`default_nettype none
`include "software_timer_pool_defines.svh"

module stp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire stp_pkg::dp_stat_t stat,
	output stp_pkg::ctl_cmd_t      ctl
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_ADD   = 9'b000000010,
		S_KRD   = 9'b000000100,
		S_KCHK  = 9'b000001000,
		S_KFIRE = 9'b000010000,
		S_REPLY = 9'b000100000,
		S_TRD   = 9'b001000000,
		S_TUPD  = 9'b010000000,
		S_TEND  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					case (stat.req_cmd)
						stp_pkg::CMD_ADD:   state_d = S_ADD;
						stp_pkg::CMD_KILL:  state_d = S_KRD;
						stp_pkg::CMD_QUERY: state_d = S_REPLY;
						default:            state_d = S_TRD;
					endcase
				end
			end
			S_ADD: begin
				if (stat.slot_free) begin
					ctl.add_take = 1'b1;
					state_d      = S_REPLY;
				end else if (stat.scan_last) begin
					state_d = S_REPLY;
				end else begin
					ctl.scan_inc = 1'b1;
				end
			end
			S_KRD: begin
				ctl.mem_rd = 1'b1;
				state_d    = S_KCHK;
			end
			S_KCHK: begin
				ctl.kill_chk = 1'b1;
				state_d      = (stat.kill_ok && stat.fire) ? S_KFIRE : S_REPLY;
			end
			S_KFIRE: begin
				if (stat.out_free) begin
					ctl.emit_fire = 1'b1;
					state_d       = S_REPLY;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					ctl.emit_reply = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_TRD: begin
				ctl.mem_rd = 1'b1;
				state_d    = S_TUPD;
			end
			S_TUPD: begin
				if (!stat.need_emit || stat.out_free) begin
					ctl.tick_upd = 1'b1;
					if (stat.scan_last) begin
						state_d = S_TEND;
					end else begin
						ctl.scan_inc = 1'b1;
						state_d      = S_TRD;
					end
				end
			end
			S_TEND: begin
				if (!stat.pend) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					ctl.emit_pend_last = 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`STP_ASSERT_IMPL(a_load_room, ctl.emit_fire || ctl.emit_reply || ctl.emit_pend_last, stat.out_free)
	`STP_ASSERT_NEXT(a_busy_after_accept, ctl.accept, !req_ready)
	`STP_ASSERT_IMPL(a_scan_bound, ctl.scan_inc, !stat.scan_last)

endmodule

`default_nettype wire

/* rtl/software_timer_pool.sv */
// One item at a time; a tick sweeps every slot through the single count-memory port,
// a read then a read-modify-write per slot. Output stalls add cycles only while a
// result waits in the result register.
// Reset (arst_n low, async): controller idle, running flags, pending expiry and
// result valid cleared; the count memory needs no clear since free slots ignore it.
`default_nettype none

module software_timer_pool #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stp_cmd_if.sink     cmd,
	stp_res_if.source   res
);

	// command/status between the sequencer and the datapath
	stp_pkg::ctl_cmd_t ctl;
	stp_pkg::dp_stat_t stat;

	// Sequencer: owns the command handshake; holds ready low from the
	// accepted item until its last result is in the result register.
	stp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.req_ready (cmd.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Datapath: running flags in flops, counts in a one-port memory with
	// registered read, plus a one-deep result register that frees the next
	// slot of the sweep while the sink still holds off.
	// Expiries found during a tick are held back by one so the final one
	// can be flagged as last when the sweep ends.
	stp_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.req_command    (cmd.command),
		.req_timeout_ms (cmd.timeout_ms),
		.req_timer_id   (cmd.timer_id),
		.req_fire_now   (cmd.fire_now),
		.rsp_ready      (res.ready),
		.rsp_valid      (res.valid),
		.rsp_kind       (res.kind),
		.rsp_slot_id    (res.slot_id),
		.rsp_success    (res.success),
		.rsp_running    (res.running),
		.rsp_last       (res.last)
	);

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the software timer pool: random commands against a predictor.
`timescale 1ns / 100ps

module tb;

	localparam int NUM_TIMERS = 16;
	// The longest command is a tick; the tail wait covers a tick that emits nothing.
	localparam int TAIL_CYCLES = 2 * NUM_TIMERS + 20;
	// Cycles with no command or result taken before the run is declared hung.
	localparam int IDLE_LIMIT = 4000;
	localparam int NUM_ITEMS = 410;

	// One command item as driven on the command channel.
	typedef struct packed {
		logic [stp_pkg::CMD_W-1:0]  command;
		logic [stp_pkg::TIME_W-1:0] timeout_ms;
		logic [stp_pkg::ID_W-1:0]   timer_id;
		logic                       fire_now;
	} timer_cmd_t;

	// One result item as seen on the result channel.
	typedef struct packed {
		logic [stp_pkg::CMD_W-1:0] kind;
		logic [stp_pkg::ID_W-1:0]  slot_id;
		logic                      success;
		logic                      running;
		logic                      last;
	} timer_event_t;

	logic clk;
	logic arst_n;

	stp_cmd_if cmd_ch ();
	stp_res_if res_ch ();

	software_timer_pool #(
		.NUM_TIMERS(NUM_TIMERS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// Stimulus and scoreboard storage.
	timer_cmd_t   pending_cmds[$];
	timer_event_t expected_events[$];

	// Shadow copy of the pool state.
	logic [stp_pkg::TIME_W-1:0] ticks_left [NUM_TIMERS];
	bit                         slot_busy  [NUM_TIMERS];

	// Handshake bookkeeping.
	bit          cmd_taken;
	bit          res_taken;
	int unsigned idle_cycles;
	int unsigned cmd_gap;
	int unsigned cmd_calm;
	int unsigned res_stall;
	int unsigned res_calm;
	int unsigned fail_count;

	// Zero timeouts pin a slot forever, so only a couple are allowed in the random part.
	int unsigned zero_budget;

	// Coverage tallies for the summary.
	int unsigned n_add, n_kill, n_query, n_tick;
	int unsigned n_expire, n_full, n_multi, n_kill_ok;

	//--------------------------------------------------------------------
	// Clock
	//--------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	//--------------------------------------------------------------------
	// Idle gap picker shared by both sides: mostly zero, some short, a few
	// long, and now and then a calm stretch with no gaps at all.
	//--------------------------------------------------------------------
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_cmd(input logic [stp_pkg::CMD_W-1:0] command,
		input logic [stp_pkg::TIME_W-1:0] timeout_ms,
		input logic [stp_pkg::ID_W-1:0] timer_id, input logic fire_now);
		timer_cmd_t c;
		c.command    = command;
		c.timeout_ms = timeout_ms;
		c.timer_id   = timer_id;
		c.fire_now   = fire_now;
		pending_cmds.push_back(c);
	endtask

	// Kill/query id: mostly a real slot, sometimes 0 or out of range (17..31).
	function automatic logic [stp_pkg::ID_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 88)
			return stp_pkg::ID_W'($urandom_range(1, NUM_TIMERS));
		if (r < 93)
			return '0;
		return stp_pkg::ID_W'($urandom_range(NUM_TIMERS + 1, 31));
	endfunction

	//--------------------------------------------------------------------
	// Predictor: applies one accepted command to the shadow state and
	// queues the result items it causes, last flag on the final one.
	//--------------------------------------------------------------------
	task automatic predict_command(input timer_cmd_t c);
		timer_event_t ev;
		timer_event_t batch[$];
		bit           in_range;
		bit           found;
		int           idx;
		in_range = (int'(c.timer_id) >= 1) && (int'(c.timer_id) <= NUM_TIMERS);
		idx = in_range ? int'(c.timer_id) - 1 : 0;
		ev = '0;
		case (c.command)
			stp_pkg::CMD_ADD: begin
				n_add++;
				found = 1'b0;
				ev.kind = stp_pkg::KIND_ADD;
				// lowest free slot wins
				for (int i = 0; i < NUM_TIMERS && !found; i++) begin
					if (!slot_busy[i]) begin
						slot_busy[i] = 1'b1;
						ticks_left[i] = c.timeout_ms;
						ev.slot_id = stp_pkg::ID_W'(i + 1);
						ev.success = 1'b1;
						found = 1'b1;
					end
				end
				if (!found)
					n_full++;
				batch.push_back(ev);
			end
			stp_pkg::CMD_KILL: begin
				n_kill++;
				ev.kind = stp_pkg::KIND_KILL;
				ev.slot_id = c.timer_id;
				// a zero count cannot be killed
				ev.success = in_range && slot_busy[idx] && (ticks_left[idx] != '0);
				if (ev.success) begin
					n_kill_ok++;
					slot_busy[idx] = 1'b0;
					ticks_left[idx] = '0;
					if (c.fire_now) begin
						timer_event_t fire_ev;
						fire_ev = '0;
						fire_ev.kind = stp_pkg::KIND_EXPIRE;
						fire_ev.slot_id = c.timer_id;
						batch.push_back(fire_ev);
					end
				end
				batch.push_back(ev);
			end
			stp_pkg::CMD_QUERY: begin
				n_query++;
				ev.kind = stp_pkg::KIND_QUERY;
				ev.slot_id = c.timer_id;
				ev.running = in_range && slot_busy[idx];
				batch.push_back(ev);
			end
			default: begin
				n_tick++;
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (slot_busy[i] && ticks_left[i] != '0) begin
						ticks_left[i] = ticks_left[i] - stp_pkg::TIME_W'(1);
						if (ticks_left[i] == '0) begin
							slot_busy[i] = 1'b0;
							ev = '0;
							ev.kind = stp_pkg::KIND_EXPIRE;
							ev.slot_id = stp_pkg::ID_W'(i + 1);
							batch.push_back(ev);
						end
					end
				end
				if (batch.size() > 1)
					n_multi++;
			end
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k]) begin
			if (batch[k].kind == stp_pkg::KIND_EXPIRE)
				n_expire++;
			expected_events.push_back(batch[k]);
		end
	endtask

	// Compare one received result with the oldest expectation, field by field.
	task automatic check_event(input timer_event_t got);
		timer_event_t want;
		if (expected_events.size() == 0) begin
			$error("unexpected result: kind %0d slot_id %0d", got.kind, got.slot_id);
			fail_count++;
			return;
		end
		want = expected_events.pop_front();
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			fail_count++;
		end
		if (got.slot_id !== want.slot_id) begin
			$error("slot_id: expected %0d, got %0d", want.slot_id, got.slot_id);
			fail_count++;
		end
		if (got.success !== want.success) begin
			$error("success: expected %0d, got %0d", want.success, got.success);
			fail_count++;
		end
		if (got.running !== want.running) begin
			$error("running: expected %0d, got %0d", want.running, got.running);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			fail_count++;
		end
	endtask

	//--------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge. Inputs move only
	// on the falling edge, so the values seen here are the settled ones.
	//--------------------------------------------------------------------
	always @(posedge clk) begin
		timer_cmd_t   c;
		timer_event_t r;
		cmd_taken = arst_n && cmd_ch.valid && cmd_ch.ready;
		res_taken = arst_n && res_ch.valid && res_ch.ready;
		if (cmd_taken) begin
			c.command    = cmd_ch.command;
			c.timeout_ms = cmd_ch.timeout_ms;
			c.timer_id   = cmd_ch.timer_id;
			c.fire_now   = cmd_ch.fire_now;
			predict_command(c);
		end
		if (res_taken) begin
			r.kind    = res_ch.kind;
			r.slot_id = res_ch.slot_id;
			r.success = res_ch.success;
			r.running = res_ch.running;
			r.last    = res_ch.last;
			check_event(r);
		end
		idle_cycles = (cmd_taken || res_taken) ? 0 : idle_cycles + 1;
	end

	//--------------------------------------------------------------------
	// Command driver: holds an item until it is taken, then waits out a
	// random gap before presenting the next one. One NBA per signal.
	//--------------------------------------------------------------------
	always @(negedge clk) begin
		timer_cmd_t nxt;
		if (arst_n && !(cmd_ch.valid && !cmd_taken)) begin
			if (cmd_gap > 0) begin
				cmd_ch.valid <= 1'b0;
				cmd_gap <= cmd_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				nxt = pending_cmds.pop_front();
				cmd_ch.valid      <= 1'b1;
				cmd_ch.command    <= nxt.command;
				cmd_ch.timeout_ms <= nxt.timeout_ms;
				cmd_ch.timer_id   <= nxt.timer_id;
				cmd_ch.fire_now   <= nxt.fire_now;
				cmd_gap <= pick_gap(cmd_calm);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: ready drops for random stretches.
	always @(negedge clk) begin
		if (res_stall > 0) begin
			res_ch.ready <= 1'b0;
			res_stall <= res_stall - 1;
		end else begin
			res_ch.ready <= 1'b1;
			res_stall <= pick_gap(res_calm);
		end
	end

	//--------------------------------------------------------------------
	// Watchdog: a hang shows up as a long run of cycles with no item moving.
	//--------------------------------------------------------------------
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("watchdog: no progress for %0d cycles, %0d results outstanding",
			IDLE_LIMIT, expected_events.size());
		$display("CHECKS FAILED");
		$finish;
	end

	//--------------------------------------------------------------------
	// Stimulus, reset and end of run.
	//--------------------------------------------------------------------
	initial begin
		int unsigned mode;
		int unsigned n;
		int unsigned t;
		logic [stp_pkg::TIME_W-1:0] tmo;

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = stp_pkg::CMD_ADD;
		cmd_ch.timeout_ms = '0;
		cmd_ch.timer_id = '0;
		cmd_ch.fire_now = 1'b0;
		res_ch.ready = 1'b0;
		cmd_taken = 1'b0;
		res_taken = 1'b0;
		idle_cycles = 0;
		cmd_gap = 0;
		cmd_calm = 0;
		res_stall = 0;
		res_calm = 0;
		fail_count = 0;
		zero_budget = 2;
		{n_add, n_kill, n_query, n_tick} = '0;
		{n_expire, n_full, n_multi, n_kill_ok} = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			ticks_left[i] = '0;
			slot_busy[i] = 1'b0;
		end

		// Directed part: edge timeouts, bad ids, every kill outcome, ticks.
		push_cmd(stp_pkg::CMD_ADD, 16'd0, '0, 1'b0);         // slot 1 held forever
		push_cmd(stp_pkg::CMD_ADD, 16'hFFFF, '0, 1'b0);      // slot 2, max timeout
		push_cmd(stp_pkg::CMD_ADD, 16'd1, '0, 1'b0);         // slot 3
		push_cmd(stp_pkg::CMD_ADD, 16'd2, '0, 1'b0);         // slot 4
		push_cmd(stp_pkg::CMD_QUERY, '0, 5'd1, 1'b0);
		push_cmd(stp_pkg::CMD_QUERY, '0, 5'd0, 1'b0);        // id zero
		push_cmd(stp_pkg::CMD_QUERY, '0, 5'd31, 1'b0);       // id above pool
		push_cmd(stp_pkg::CMD_KILL, '0, 5'd1, 1'b1);         // zero count: refused
		push_cmd(stp_pkg::CMD_KILL, '0, 5'd2, 1'b1);         // ok, with expiry first
		push_cmd(stp_pkg::CMD_KILL, '0, 5'd2, 1'b0);         // already free
		push_cmd(stp_pkg::CMD_KILL, '0, 5'd0, 1'b1);
		push_cmd(stp_pkg::CMD_KILL, '0, 5'd17, 1'b1);
		push_cmd(stp_pkg::CMD_TICK, '0, '0, 1'b0);           // slot 3 expires
		push_cmd(stp_pkg::CMD_TICK, '0, '0, 1'b0);           // slot 4 expires
		push_cmd(stp_pkg::CMD_TICK, '0, '0, 1'b0);           // nothing left to expire
		push_cmd(stp_pkg::CMD_ADD, 16'd3, '0, 1'b0);         // reuses slot 2
		push_cmd(stp_pkg::CMD_KILL, '0, 5'd2, 1'b0);         // ok, reply only
		push_cmd(stp_pkg::CMD_QUERY, '0, 5'd16, 1'b0);
		push_cmd(stp_pkg::CMD_ADD, 16'hAAAA, '0, 1'b0);
		push_cmd(stp_pkg::CMD_ADD, 16'h5555, '0, 1'b0);
		push_cmd(stp_pkg::CMD_ADD, 16'd1, '0, 1'b0);
		push_cmd(stp_pkg::CMD_ADD, 16'd1, '0, 1'b0);
		push_cmd(stp_pkg::CMD_TICK, '0, '0, 1'b0);           // two expiries in one tick
		push_cmd(stp_pkg::CMD_QUERY, '0, 5'd2, 1'b0);

		// Random part in episodes: fill the pool, drain it, run short timers
		// out with ticks, or throw fully random commands at it.
		while (pending_cmds.size() < NUM_ITEMS) begin
			mode = $urandom_range(0, 99);
			if (mode < 20) begin
				n = $urandom_range(10, 18);
				repeat (n) begin
					tmo = ($urandom_range(0, 4) == 0)
						? stp_pkg::TIME_W'($urandom_range(1, 30))
						: stp_pkg::TIME_W'($urandom_range(500, 65535));
					push_cmd(stp_pkg::CMD_ADD, tmo, pick_id(), 1'($urandom_range(0, 1)));
				end
			end else if (mode < 45) begin
				n = $urandom_range(6, 16);
				repeat (n) begin
					if ($urandom_range(0, 5) == 0)
						push_cmd(stp_pkg::CMD_QUERY, stp_pkg::TIME_W'($urandom_range(0, 65535)),
							pick_id(), 1'b0);
					else
						push_cmd(stp_pkg::CMD_KILL, stp_pkg::TIME_W'($urandom_range(0, 65535)),
							pick_id(), 1'($urandom_range(0, 1)));
				end
			end else if (mode < 80) begin
				n = $urandom_range(1, 6);
				t = $urandom_range(1, 6);
				repeat (n) begin
					// same timeout half the time so several slots expire together
					tmo = ($urandom_range(0, 1) != 0) ? stp_pkg::TIME_W'(t)
						: stp_pkg::TIME_W'($urandom_range(1, 8));
					push_cmd(stp_pkg::CMD_ADD, tmo, '0, 1'b0);
				end
				n = $urandom_range(1, 9);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0)
						push_cmd(stp_pkg::CMD_QUERY, '0, pick_id(), 1'b0);
					push_cmd(stp_pkg::CMD_TICK, stp_pkg::TIME_W'($urandom_range(0, 65535)),
						stp_pkg::ID_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
				end
			end else begin
				n = $urandom_range(4, 12);
				repeat (n) begin
					if (zero_budget > 0 && $urandom_range(0, 99) == 0) begin
						tmo = '0;
						zero_budget--;
					end else begin
						tmo = stp_pkg::TIME_W'($urandom_range(1, 65535));
					end
					push_cmd(stp_pkg::CMD_W'($urandom_range(0, 3)), tmo,
						stp_pkg::ID_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
				end
			end
		end

		// Single reset at the start, released on a falling edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all items sent, all results back, then a tail for a silent tick.
		@(posedge clk);
		while (pending_cmds.size() > 0 || cmd_ch.valid || expected_events.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("commands: %0d add (%0d on a full pool), %0d kill (%0d ok), %0d query, %0d tick",
			n_add, n_full, n_kill, n_kill_ok, n_query, n_tick);
		$display("expiry items: %0d, ticks with several expiries: %0d, mismatches: %0d",
			n_expire, n_multi, fail_count);
		if (fail_count == 0 && expected_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_cmd_if.sv
rtl/stp_res_if.sv
rtl/stp_datapath.sv
rtl/stp_ctrl.sv
rtl/software_timer_pool.sv
dv/tb.sv
